// ----- rtl/core/group_membership_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// group membership table assertion macros
// Concurrent check wrappers used by the table unit; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef GROUP_MEMBERSHIP_TABLE_UNIT_DEFINES_SVH
`define GROUP_MEMBERSHIP_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define GMT_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gmt: invariant check failed");

// consequent holds in the cycle after the antecedent
`define GMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmt: sequence check failed");

`else

`define GMT_ASSERT_ALWAYS(label, clk, rst, cond)
`define GMT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/gmt_pkg.sv -----
// ----------------------------------------------------------------------------
// gmt_pkg
// Sizes, request and response types and sequencer states of the group
// membership table.
// ----------------------------------------------------------------------------
package gmt_pkg;

  // table geometry
  localparam int GROUP_SLOTS       = 16;
  localparam int MEMBERS_PER_GROUP = 16;

  // derived widths
  localparam int SLOT_W      = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int GIU_W       = $clog2(GROUP_SLOTS + 1);
  localparam int MIDX_W      = (MEMBERS_PER_GROUP > 1) ? $clog2(MEMBERS_PER_GROUP) : 1;
  localparam int CNT_W       = $clog2(MEMBERS_PER_GROUP + 1);
  localparam int STORE_DEPTH = GROUP_SLOTS * MEMBERS_PER_GROUP;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // fixed field widths
  localparam int ADDR_W      = 16;
  localparam int INDEX_W     = 4;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    REQ_SUBSCRIBE   = 2'd0,
    REQ_UNSUBSCRIBE = 2'd1,
    REQ_QUERY       = 2'd2,
    REQ_READ        = 2'd3
  } gmt_req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_ROOM   = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } gmt_status_t;

  typedef struct packed {
    gmt_req_type_t       req_type;
    logic [ADDR_W-1:0]   group_address;
    logic [ADDR_W-1:0]   node_address;
    logic [INDEX_W-1:0]  member_index;
  } gmt_req_t;

  typedef struct packed {
    gmt_status_t             status;
    logic                    changed;
    logic [COUNT_OUT_W-1:0]  member_count;
    logic                    is_member;
    logic [ADDR_W-1:0]       member_address;
  } gmt_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GROUP_SCAN,
    ST_MEMBER_READ,
    ST_MEMBER_CMP,
    ST_APPLY,
    ST_READ_WAIT,
    ST_SHIFT_READ,
    ST_SHIFT_WRITE,
    ST_FINISH
  } gmt_state_t;

endpackage

// ----- rtl/core/gmt_ram.sv -----
// ----------------------------------------------------------------------------
// gmt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module gmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/group_membership_table_unit.sv -----
// ----------------------------------------------------------------------------
// group_membership_table_unit: scans the used group slots one by one, then
// reads and compares the group's members, then applies the request; a read
// waits for the member store and an unsubscribe shifts later entries down
// one by one. One request at a time; the next is taken from the cycle in
// which the result turns valid. Reset clears sequencer, slot count, flag
// ----------------------------------------------------------------------------
`include "group_membership_table_unit_defines.svh"

module group_membership_table_unit
  import gmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  gmt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output gmt_rsp_t rsp
);
  // reset clears the sequencer, the slot count and the response flag; the
  // tables need no clearing since only slots and members in use are read

  // member store address of a slot and list position
  function automatic logic [STORE_AW-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                     input logic [MIDX_W-1:0] m);
    store_addr = STORE_AW'(32'(s) * MEMBERS_PER_GROUP + 32'(m));
  endfunction

  gmt_state_t state, state_next;

  // group table
  logic [GIU_W-1:0]  giu, giu_next;
  logic [ADDR_W-1:0] grp_addr [GROUP_SLOTS];
  logic [CNT_W-1:0]  grp_cnt  [GROUP_SLOTS];
  logic              grp_we;
  logic [SLOT_W-1:0] grp_widx;
  logic              cnt_we;
  logic [SLOT_W-1:0] cnt_widx;
  logic [CNT_W-1:0]  cnt_wval;

  // working registers
  gmt_req_t          req_q, req_next;
  logic [GIU_W-1:0]  scan, scan_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic              grp_found, grp_found_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  midx, midx_next;
  logic [CNT_W-1:0]  midx_inc;
  logic              mem_found, mem_found_next;
  gmt_rsp_t          res, res_next;
  gmt_rsp_t          rsp_q, rsp_next;
  logic              rsp_valid_q, rsp_valid_next;

  // member store port
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [ADDR_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [STORE_AW-1:0] ram_raddr;
  logic [ADDR_W-1:0]   ram_rdata;

  gmt_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(STORE_DEPTH)
  ) u_member_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign midx_inc  = midx + CNT_W'(1);
  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      giu         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      giu         <= giu_next;
      rsp_valid_q <= rsp_valid_next;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    req_q     <= req_next;
    scan      <= scan_next;
    slot      <= slot_next;
    grp_found <= grp_found_next;
    cnt       <= cnt_next;
    midx      <= midx_next;
    mem_found <= mem_found_next;
    res       <= res_next;
    rsp_q     <= rsp_next;
  end

  // group address and member count tables
  always_ff @(posedge clk) begin
    if (grp_we) begin
      grp_addr[grp_widx] <= req_q.group_address;
    end
    if (cnt_we) begin
      grp_cnt[cnt_widx] <= cnt_wval;
    end
  end

  // sequencer
  always_comb begin
    state_next     = state;
    giu_next       = giu;
    req_next       = req_q;
    scan_next      = scan;
    slot_next      = slot;
    grp_found_next = grp_found;
    cnt_next       = cnt;
    midx_next      = midx;
    mem_found_next = mem_found;
    res_next       = res;
    rsp_next       = rsp_q;
    rsp_valid_next = rsp_valid_q;
    grp_we         = 1'b0;
    grp_widx       = slot;
    cnt_we         = 1'b0;
    cnt_widx       = slot;
    cnt_wval       = cnt;
    ram_we         = 1'b0;
    ram_waddr      = store_addr(slot, midx[MIDX_W-1:0]);
    ram_wdata      = req_q.node_address;
    ram_re         = 1'b0;
    ram_raddr      = store_addr(slot, midx[MIDX_W-1:0]);

    // response transfer frees the output register
    if (rsp_valid_q && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          req_next       = req;
          scan_next      = '0;
          grp_found_next = 1'b0;
          mem_found_next = 1'b0;
          cnt_next       = '0;
          midx_next      = '0;
          state_next     = ST_GROUP_SCAN;
        end
      end

      // one slot compared per cycle
      ST_GROUP_SCAN: begin
        if (scan == giu) begin
          state_next = ST_APPLY;
        end else if (grp_addr[scan[SLOT_W-1:0]] == req_q.group_address) begin
          grp_found_next = 1'b1;
          slot_next      = scan[SLOT_W-1:0];
          cnt_next       = grp_cnt[scan[SLOT_W-1:0]];
          state_next     = ST_MEMBER_READ;
        end else begin
          scan_next = scan + GIU_W'(1);
        end
      end

      // member scan: read, then compare
      ST_MEMBER_READ: begin
        if (midx == cnt) begin
          state_next = ST_APPLY;
        end else begin
          ram_re     = 1'b1;
          state_next = ST_MEMBER_CMP;
        end
      end

      ST_MEMBER_CMP: begin
        if (ram_rdata == req_q.node_address) begin
          mem_found_next = 1'b1;
          state_next     = ST_APPLY;
        end else begin
          midx_next  = midx_inc;
          state_next = ST_MEMBER_READ;
        end
      end

      // act on the request once group and member lookups are done
      ST_APPLY: begin
        res_next.status         = STATUS_OK;
        res_next.changed        = 1'b0;
        res_next.member_count   = grp_found ? COUNT_OUT_W'(cnt) : '0;
        res_next.is_member      = mem_found;
        res_next.member_address = '0;
        state_next              = ST_FINISH;
        unique case (req_q.req_type)
          REQ_SUBSCRIBE: begin
            if (grp_found) begin
              if (!mem_found) begin
                if (cnt == CNT_W'(MEMBERS_PER_GROUP)) begin
                  res_next.status = STATUS_NO_ROOM;
                end else begin
                  ram_we                = 1'b1;
                  ram_waddr             = store_addr(slot, cnt[MIDX_W-1:0]);
                  cnt_we                = 1'b1;
                  cnt_wval              = cnt + CNT_W'(1);
                  res_next.changed      = 1'b1;
                  res_next.member_count = COUNT_OUT_W'(cnt + CNT_W'(1));
                  res_next.is_member    = 1'b1;
                end
              end
            end else if (giu == GIU_W'(GROUP_SLOTS)) begin
              res_next.status = STATUS_NO_ROOM;
            end else begin
              // open the next free slot
              grp_we                = 1'b1;
              grp_widx              = giu[SLOT_W-1:0];
              cnt_we                = 1'b1;
              cnt_widx              = giu[SLOT_W-1:0];
              cnt_wval              = CNT_W'(1);
              ram_we                = 1'b1;
              ram_waddr             = store_addr(giu[SLOT_W-1:0], '0);
              giu_next              = giu + GIU_W'(1);
              res_next.changed      = 1'b1;
              res_next.member_count = COUNT_OUT_W'(1);
              res_next.is_member    = 1'b1;
            end
          end
          REQ_UNSUBSCRIBE: begin
            if (!grp_found || !mem_found) begin
              res_next.status = STATUS_NOT_FOUND;
            end else begin
              state_next = ST_SHIFT_READ;
            end
          end
          REQ_QUERY: begin
            if (!grp_found) begin
              res_next.status = STATUS_NOT_FOUND;
            end
          end
          REQ_READ: begin
            if (!grp_found || (32'(req_q.member_index) >= 32'(cnt))) begin
              res_next.status = STATUS_NOT_FOUND;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = store_addr(slot, MIDX_W'(req_q.member_index));
              state_next = ST_READ_WAIT;
            end
          end
        endcase
      end

      ST_READ_WAIT: begin
        res_next.member_address = ram_rdata;
        state_next              = ST_FINISH;
      end

      // close the gap left by the removed member: each later entry is read, then written one place lower
      ST_SHIFT_READ: begin
        if (midx_inc >= cnt) begin
          cnt_we                = 1'b1;
          cnt_wval              = cnt - CNT_W'(1);
          res_next.changed      = 1'b1;
          res_next.member_count = COUNT_OUT_W'(cnt - CNT_W'(1));
          res_next.is_member    = 1'b0;
          state_next            = ST_FINISH;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = store_addr(slot, MIDX_W'(midx_inc));
          state_next = ST_SHIFT_WRITE;
        end
      end

      ST_SHIFT_WRITE: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        midx_next  = midx_inc;
        state_next = ST_SHIFT_READ;
      end

      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_ready) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
    endcase
  end

  // checks
  `GMT_ASSERT_NEXT(a_busy_after_transfer, clk, rst, req_valid && req_ready, !req_ready)
  `GMT_ASSERT_ALWAYS(a_change_means_ok, clk, rst, !rsp_valid || !rsp.changed || rsp.status == STATUS_OK)
  `GMT_ASSERT_ALWAYS(a_slots_in_range, clk, rst, giu <= GIU_W'(GROUP_SLOTS))
  `GMT_ASSERT_ALWAYS(a_not_found_no_addr, clk, rst, !rsp_valid || rsp.status != STATUS_NOT_FOUND || rsp.member_address == '0)

endmodule

// ----- test/group_membership_table_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// group_membership_table_unit_tb
// Self-checking bench for the group membership table. A request backlog is
// filled up front with directed cases followed by random traffic over small
// group and node pools, so groups and the table fill up. Each accepted request
// updates a local copy of the table, and every response is checked field by
// field against the oldest prediction. Both sides idle in random bursts, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module group_membership_table_unit_tb;
  import gmt_pkg::*;

  localparam int RANDOM_REQUESTS = 650;
  localparam int LATE_START      = 400;  // new groups only show up after this
  localparam int EARLY_GROUPS    = 8;
  localparam int GROUP_POOL      = 20;
  localparam int NODE_POOL       = 20;
  localparam int QUIET_TAIL      = 60;   // no idling over the final transfers
  localparam int HOLD_AT         = 120;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 200;
  localparam int LIMIT_CYCLES    = 500000;

  localparam logic [ADDR_W-1:0] FULL_GROUP = 16'h5A5A;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  gmt_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  gmt_rsp_t rsp;

  group_membership_table_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  gmt_req_t request_backlog[$];
  gmt_rsp_t expected_results[$];
  int       request_total = 0;
  int       requests_sent = 0;
  int       responses_seen = 0;
  int       error_count = 0;
  int       cycle_count = 0;

  logic [ADDR_W-1:0] group_pool [GROUP_POOL];
  logic [ADDR_W-1:0] node_pool [NODE_POOL];

  // local copy of the table
  int                slots_used = 0;
  logic [ADDR_W-1:0] slot_group [GROUP_SLOTS];
  int                slot_count [GROUP_SLOTS];
  logic [ADDR_W-1:0] slot_members [GROUP_SLOTS][MEMBERS_PER_GROUP];

  function automatic int find_group(logic [ADDR_W-1:0] g);
    for (int i = 0; i < slots_used; i++)
      if (slot_group[i] == g) return i;
    return -1;
  endfunction

  function automatic int find_node(int s, logic [ADDR_W-1:0] n);
    for (int j = 0; j < slot_count[s]; j++)
      if (slot_members[s][j] == n) return j;
    return -1;
  endfunction

  // applies one request to the local table and returns the response it gives
  function automatic gmt_rsp_t update_table(gmt_req_t r);
    gmt_rsp_t o;
    int       s;
    int       pos;
    o = '0;
    o.status = STATUS_OK;
    s = find_group(r.group_address);
    case (r.req_type)
      REQ_SUBSCRIBE: begin
        if (s >= 0) begin
          if (find_node(s, r.node_address) < 0) begin
            if (slot_count[s] >= MEMBERS_PER_GROUP) begin
              o.status = STATUS_NO_ROOM;
            end else begin
              slot_members[s][slot_count[s]] = r.node_address;
              slot_count[s]++;
              o.changed = 1'b1;
            end
          end
        end else if (slots_used >= GROUP_SLOTS) begin
          o.status = STATUS_NO_ROOM;
        end else begin
          s = slots_used;
          slots_used++;
          slot_group[s] = r.group_address;
          slot_members[s][0] = r.node_address;
          slot_count[s] = 1;
          o.changed = 1'b1;
        end
      end
      REQ_UNSUBSCRIBE: begin
        pos = (s >= 0) ? find_node(s, r.node_address) : -1;
        if (pos < 0) begin
          o.status = STATUS_NOT_FOUND;
        end else begin
          // close the gap left by the removed member
          for (int k = pos; k + 1 < slot_count[s]; k++)
            slot_members[s][k] = slot_members[s][k+1];
          slot_count[s]--;
          o.changed = 1'b1;
        end
      end
      REQ_QUERY: begin
        if (s < 0) o.status = STATUS_NOT_FOUND;
      end
      default: begin
        if (s < 0 || int'(r.member_index) >= slot_count[s])
          o.status = STATUS_NOT_FOUND;
        else
          o.member_address = slot_members[s][r.member_index];
      end
    endcase
    if (s >= 0) begin
      o.member_count = slot_count[s][COUNT_OUT_W-1:0];
      o.is_member = (find_node(s, r.node_address) >= 0);
    end
    return o;
  endfunction

  task automatic queue_request(gmt_req_type_t t, logic [ADDR_W-1:0] g,
                               logic [ADDR_W-1:0] n, logic [INDEX_W-1:0] idx);
    gmt_req_t r;
    r.req_type = t;
    r.group_address = g;
    r.node_address = n;
    r.member_index = idx;
    request_backlog.push_back(r);
  endtask

  task automatic compare_result(gmt_rsp_t got);
    gmt_rsp_t exp;
    if (expected_results.size() == 0) begin
      $error("unexpected response transfer: %h", got);
      error_count++;
    end else begin
      exp = expected_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        error_count++;
      end
      if (got.changed !== exp.changed) begin
        $error("changed: expected %0d, actual %0d", exp.changed, got.changed);
        error_count++;
      end
      if (got.member_count !== exp.member_count) begin
        $error("member_count: expected %0d, actual %0d", exp.member_count,
               got.member_count);
        error_count++;
      end
      if (got.is_member !== exp.is_member) begin
        $error("is_member: expected %0d, actual %0d", exp.is_member, got.is_member);
        error_count++;
      end
      if (got.member_address !== exp.member_address) begin
        $error("member_address: expected %h, actual %h", exp.member_address,
               got.member_address);
        error_count++;
      end
    end
  endtask

  // request driver
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_results.push_back(update_table(req));
        requests_sent++;
        if (request_backlog.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 6);
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          req <= request_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stalls
  int  stall_cycles = 0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        compare_result(rsp);
        responses_seen++;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_ready <= 1'b0;
      end else if (!hold_done && responses_seen == HOLD_AT) begin
        // long hold-off so the block backs up into its request side
        hold_done = 1'b1;
        hold_cycles = HOLD_CYCLES - 1;
        rsp_ready <= 1'b0;
      end else if (stall_cycles > 0) begin
        stall_cycles--;
        rsp_ready <= 1'b0;
      end else if (responses_seen < request_total - QUIET_TAIL &&
                   $urandom_range(0, 4) == 0) begin
        stall_cycles = $urandom_range(0, 5);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    gmt_req_t r;
    int       roll;
    int       pick;

    for (int i = 0; i < GROUP_POOL; i++) group_pool[i] = ADDR_W'($urandom);
    for (int i = 0; i < NODE_POOL; i++) node_pool[i] = ADDR_W'($urandom);

    // directed: absent group, extremes, duplicate, member index bounds
    queue_request(REQ_READ, 16'h0000, 16'h0000, 4'd0);
    queue_request(REQ_UNSUBSCRIBE, 16'h0000, 16'h0000, 4'd0);
    queue_request(REQ_SUBSCRIBE, 16'h0000, 16'h0000, 4'd0);
    queue_request(REQ_SUBSCRIBE, 16'h0000, 16'h0000, 4'd0);
    queue_request(REQ_SUBSCRIBE, 16'hFFFF, 16'hFFFF, 4'd15);
    queue_request(REQ_READ, 16'hFFFF, 16'hFFFF, 4'd0);
    queue_request(REQ_READ, 16'hFFFF, 16'hFFFF, 4'd15);
    queue_request(REQ_UNSUBSCRIBE, 16'hFFFF, 16'h1234, 4'd0);
    // fill one group, then overflow it and shift the full list
    for (int k = 0; k < MEMBERS_PER_GROUP; k++)
      queue_request(REQ_SUBSCRIBE, FULL_GROUP, ADDR_W'(32'hA000 + k), 4'd0);
    queue_request(REQ_SUBSCRIBE, FULL_GROUP, 16'hBEEF, 4'd0);
    queue_request(REQ_READ, FULL_GROUP, 16'hA000, 4'd15);
    queue_request(REQ_UNSUBSCRIBE, FULL_GROUP, 16'hA000, 4'd0);
    // emptied group keeps its slot
    queue_request(REQ_UNSUBSCRIBE, 16'h0000, 16'h0000, 4'd0);
    queue_request(REQ_QUERY, 16'h0000, 16'h0000, 4'd0);

    // random: mostly pooled addresses so groups fill, later the table fills
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      roll = $urandom_range(0, 99);
      r.member_index = INDEX_W'($urandom_range(0, 15));
      r.node_address = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom)
                                                   : node_pool[$urandom_range(0, NODE_POOL-1)];
      if (roll < 10) begin
        r.req_type = gmt_req_type_t'($urandom_range(0, 3));
        r.group_address = ADDR_W'($urandom);
        if (r.req_type == REQ_SUBSCRIBE && i < LATE_START)
          r.group_address = group_pool[$urandom_range(0, EARLY_GROUPS-1)];
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) r.req_type = REQ_SUBSCRIBE;
        else if (pick < 65) r.req_type = REQ_UNSUBSCRIBE;
        else if (pick < 80) r.req_type = REQ_QUERY;
        else r.req_type = REQ_READ;
        if (roll < 15)
          r.group_address = FULL_GROUP;
        else if (i < LATE_START)
          r.group_address = group_pool[$urandom_range(0, EARLY_GROUPS-1)];
        else
          r.group_address = group_pool[$urandom_range(0, GROUP_POOL-1)];
      end
      request_backlog.push_back(r);
    end
    request_total = request_backlog.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (requests_sent == request_total);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d responses never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/gmt_pkg.sv
rtl/core/gmt_ram.sv
rtl/core/group_membership_table_unit.sv
test/group_membership_table_unit_tb.sv
